>>> sv/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and helpers for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths fixed by the interface.
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int ACTION_W  = 2;
  localparam int COLUMN_W  = 7;
  localparam int ROW_W     = 5;
  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Character codes and the cell value left by reset.
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

  // Reset colors.
  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

  // Request actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Control states.
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_t;

  // Build a cell word from the colors and a character byte.
  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [CHAR_W-1:0]  ch);
    return {bg, fg, ch};
  endfunction

endpackage
`default_nettype wire

>>> sv/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Text-mode console: a ROWS x COLUMNS cell memory with a cursor, scrolling
// through a rotating row base.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel (valid/stall) carries an action, a
//   character byte and a row/column. Each request yields one result on the
//   out_ channel: the read cell word, the linear cursor and a scroll flag.
//   Colors are set through the cfg_ write port; keeping to idle is up to the user, the block does not enforce it.
// Request handling:
//   Put character and set cursor finish in the accept cycle; the result is
//   valid on the next cycle and, while no result is stalled, a new request
//   may be taken every cycle. Read cell goes through the registered memory
//   read and the READ state before the result register. A put that scrolls
//   rotates the row base and blanks one physical row, one cell per cycle.
//   Clear blanks every cell the same way, paced by the single write port.
// Reset:
//   After rst_n a clearing pass writes blanks (0x0720) into all
//   ROWS * COLUMNS cells, one per cycle; in_stall is high during it.
// Stalls:
//   The result sits in an output register; while it is stalled, the next
//   request is held off, otherwise a request is taken as the result leaves.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tccw_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tccw_pkg::COLUMN_W-1:0]   in_column,
  input  wire logic [tccw_pkg::ROW_W-1:0]      in_row,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [tccw_pkg::CELL_W-1:0]     out_cell_word,
  output logic      [tccw_pkg::POS_W-1:0]      out_cursor_pos,
  output logic                                 out_scrolled,
  // Configuration port
  input  wire logic                            cfg_we,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tccw_pkg::COLOR_W-1:0]    cfg_wdata
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  localparam logic [CW:0]   COLUMNS_X = (CW + 1)'(COLUMNS);
  localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW:0]   COUNT_ALL = (AW + 1)'(CELL_COUNT);
  localparam logic [AW:0]   COUNT_ROW = (AW + 1)'(COLUMNS);

  // Physical address of a logical row and column under a row base.
  function automatic logic [AW-1:0] phys_addr(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] base,
                                              input logic [CW-1:0] col);
    logic [RW:0]   sum;
    logic [RW-1:0] prow;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= ROWS_X) begin
      sum = sum - ROWS_X;
    end
    prow = sum[RW-1:0];
    return AW'(prow) * AW'(COLUMNS) + AW'(col);
  endfunction

  // Linear cursor index truncated to the result width.
  function automatic logic [tccw_pkg::POS_W-1:0] pos_of(input logic [RW-1:0] r,
                                                        input logic [CW-1:0] c);
    logic [31:0] ext;
    ext = 32'(phys_addr(r, '0, c));
    return ext[tccw_pkg::POS_W-1:0];
  endfunction

  tccw_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] base_r, base_nxt;

  logic [tccw_pkg::COLOR_W-1:0] fg_color_r;
  logic [tccw_pkg::COLOR_W-1:0] bg_color_r;

  logic [AW-1:0]                 fill_addr_r, fill_addr_nxt;
  logic [AW:0]                   fill_left_r, fill_left_nxt;
  logic [tccw_pkg::CELL_W-1:0]   fill_val_r, fill_val_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [tccw_pkg::CELL_W-1:0]   out_word_r, out_word_nxt;
  logic [tccw_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                          out_scr_r, out_scr_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;

  tccw_pkg::action_t             act;
  logic                          in_acc;
  logic                          out_take;
  logic                          fill_last;

  // Put-character decode.
  logic                          is_nl;
  logic [CW:0]                   col_inc;
  logic [RW:0]                   row_inc;
  logic                          wrap;
  logic                          do_scroll;
  logic [CW-1:0]                 put_col;
  logic [RW-1:0]                 put_row;
  logic [AW-1:0]                 put_addr;
  logic [tccw_pkg::CELL_W-1:0]   blank_cell;

  // Saturated row and column for set cursor and read cell.
  logic [CW-1:0]                 col_sat;
  logic [RW-1:0]                 row_sat;
  logic [AW-1:0]                 read_addr;

  assign act       = tccw_pkg::action_t'(in_action);
  assign out_take  = out_valid_r && !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign fill_last = (fill_left_r == (AW + 1)'(1));

  // Cursor advance for a put request.
  always_comb begin
    is_nl     = (in_char_code == tccw_pkg::NEWLINE_CHAR);
    col_inc   = {1'b0, cur_col_r} + (CW + 1)'(1);
    row_inc   = {1'b0, cur_row_r} + (RW + 1)'(1);
    wrap      = is_nl || (col_inc == COLUMNS_X);
    do_scroll = wrap && (row_inc == ROWS_X);
    put_col   = wrap ? '0 : col_inc[CW-1:0];
    if (!wrap) begin
      put_row = cur_row_r;
    end else if (do_scroll) begin
      put_row = ROW_LAST;
    end else begin
      put_row = row_inc[RW-1:0];
    end
    put_addr   = phys_addr(cur_row_r, base_r, cur_col_r);
    blank_cell = tccw_pkg::make_cell(fg_color_r, bg_color_r, tccw_pkg::BLANK_CHAR);
  end

  // Saturation of the requested position.
  always_comb begin
    col_sat   = (32'(in_column) > 32'(COLUMNS - 1)) ? COL_LAST : CW'(in_column);
    row_sat   = (32'(in_row) > 32'(ROWS - 1)) ? ROW_LAST : RW'(in_row);
    read_addr = phys_addr(row_sat, base_r, col_sat);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tccw_pkg::ST_INIT: begin
        if (fill_last) begin
          state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (act)
            tccw_pkg::ACT_PUT:   state_nxt = do_scroll ? tccw_pkg::ST_FILL : tccw_pkg::ST_IDLE;
            tccw_pkg::ACT_CLEAR: state_nxt = tccw_pkg::ST_FILL;
            tccw_pkg::ACT_SET:   state_nxt = tccw_pkg::ST_IDLE;
            tccw_pkg::ACT_READ:  state_nxt = tccw_pkg::ST_READ;
            default:             state_nxt = tccw_pkg::ST_IDLE;
          endcase
        end
      end
      tccw_pkg::ST_READ: state_nxt = tccw_pkg::ST_IDLE;
      tccw_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tccw_pkg::ST_INIT;
    endcase
  end

  // Memory port control and request stall.
  always_comb begin
    in_stall  = (state_r != tccw_pkg::ST_IDLE) || (out_valid_r && out_stall);
    ram_raddr = read_addr;
    if (state_r == tccw_pkg::ST_INIT || state_r == tccw_pkg::ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr_r;
      ram_wdata = fill_val_r;
    end else begin
      ram_we    = (state_r == tccw_pkg::ST_IDLE) && in_acc &&
                  (act == tccw_pkg::ACT_PUT) && !is_nl;
      ram_waddr = put_addr;
      ram_wdata = tccw_pkg::make_cell(fg_color_r, bg_color_r, in_char_code);
    end
  end

  // Datapath next values.
  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    fill_addr_nxt = fill_addr_r;
    fill_left_nxt = fill_left_r;
    fill_val_nxt  = fill_val_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_word_nxt  = out_word_r;
    out_pos_nxt   = out_pos_r;
    out_scr_nxt   = out_scr_r;
    unique case (state_r)
      tccw_pkg::ST_INIT: begin
        fill_addr_nxt = fill_addr_r + AW'(1);
        fill_left_nxt = fill_left_r - (AW + 1)'(1);
      end
      tccw_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_word_nxt = '0;
          out_scr_nxt  = 1'b0;
          unique case (act)
            tccw_pkg::ACT_PUT: begin
              cur_row_nxt = put_row;
              cur_col_nxt = put_col;
              out_pos_nxt = pos_of(put_row, put_col);
              out_scr_nxt = do_scroll;
              if (do_scroll) begin
                // The oldest physical row becomes the new bottom row.
                base_nxt      = (base_r == ROW_LAST) ? '0 : base_r + RW'(1);
                fill_addr_nxt = AW'(base_r) * AW'(COLUMNS);
                fill_left_nxt = COUNT_ROW;
                fill_val_nxt  = blank_cell;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            tccw_pkg::ACT_CLEAR: begin
              cur_row_nxt   = '0;
              cur_col_nxt   = '0;
              base_nxt      = '0;
              fill_addr_nxt = '0;
              fill_left_nxt = COUNT_ALL;
              fill_val_nxt  = blank_cell;
              out_pos_nxt   = '0;
            end
            tccw_pkg::ACT_SET: begin
              cur_row_nxt   = row_sat;
              cur_col_nxt   = col_sat;
              out_pos_nxt   = pos_of(row_sat, col_sat);
              out_valid_nxt = 1'b1;
            end
            tccw_pkg::ACT_READ: begin
              out_pos_nxt = pos_of(cur_row_r, cur_col_r);
            end
            default: begin
              out_pos_nxt = out_pos_r;
            end
          endcase
        end
      end
      tccw_pkg::ST_READ: begin
        out_word_nxt  = ram_rdata;
        out_valid_nxt = 1'b1;
      end
      tccw_pkg::ST_FILL: begin
        fill_addr_nxt = fill_addr_r + AW'(1);
        fill_left_nxt = fill_left_r - (AW + 1)'(1);
        if (fill_last) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        fill_left_nxt = fill_left_r;
      end
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_INIT;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      fill_addr_r <= '0;
      fill_left_r <= COUNT_ALL;
      fill_val_r  <= tccw_pkg::RESET_CELL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_left_r <= fill_left_nxt;
      fill_val_r  <= fill_val_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    out_pos_r  <= out_pos_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // Color registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r <= tccw_pkg::FG_RESET;
      bg_color_r <= tccw_pkg::BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tccw_pkg::REG_FG_COLOR: fg_color_r <= cfg_wdata;
        tccw_pkg::REG_BG_COLOR: bg_color_r <= cfg_wdata;
        default:                fg_color_r <= fg_color_r;
      endcase
    end
  end

  // Cell memory.
  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cell_word  = out_word_r;
  assign out_cursor_pos = out_pos_r;
  assign out_scrolled   = out_scr_r;

  // A scrolled result always leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scr_r |-> (cur_col_r == '0) && (cur_row_r == ROW_LAST))
    else $error("scroll result with cursor off the bottom row start");

  // The last fill step of a request delivers its result.
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tccw_pkg::ST_FILL) && fill_last |=>
      out_valid_r && (state_r == tccw_pkg::ST_IDLE))
    else $error("fill finished without a result");

  // Cursor and row base stay on the screen.
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= ROW_LAST) && (cur_col_r <= COL_LAST) && (base_r <= ROW_LAST))
    else $error("cursor or row base out of range");

endmodule
`default_nettype wire
